// ----- hw/rtl/otr_pkg.sv -----
// ----------------------------------------------------------------------------
// otr_pkg: shared types and constants
// Register indexes, codes and the control/status bundles that join the
// trip controller and its datapath.
// ----------------------------------------------------------------------------
package otr_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_TRIP_CURRENT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PROG_MODE     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT        = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MA_PER_COUNT  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RETRY         = 3'd5;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_POWER = 1'b1;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_OFF  = 2'd1;
  localparam logic [1:0] EV_ON   = 2'd2;

  localparam logic [15:0] PROG_LIMIT_MA = 16'd250;
  localparam logic [8:0]  WEIGHT_ONE    = 9'd256;
  localparam logic [8:0]  CHECK_MAX     = 9'h1FF;
  localparam logic [16:0] TRIP_MAX      = 17'h1FFFF;
  localparam logic [15:0] CURRENT_MAX   = 16'hFFFF;

  localparam logic [15:0] RST_TRIP_CURRENT = 16'd2000;
  localparam logic [8:0]  RST_WEIGHT       = 9'd26;
  localparam logic [15:0] RST_MA_PER_COUNT = 16'd2503;
  localparam logic [7:0]  RST_INTERVAL     = 8'd1;
  localparam logic [15:0] RST_RETRY        = 16'd10000;

  typedef struct packed {
    logic accept;
    logic load_prod;
    logic load_avg;
    logic load_scale;
    logic commit;
  } otr_cmd_t;

  typedef struct packed {
    logic check_hit;
    logic slot_free;
  } otr_status_t;

endpackage

// ----- hw/rtl/otr_if.sv -----
// ----------------------------------------------------------------------------
// otr_if: item and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface otr_in_if #(parameter int SAMPLE_BITS = 10);
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [SAMPLE_BITS-1:0] sense_sample;
  logic                   power_on;
  logic                   announce;

  modport source (output valid, op, sense_sample, power_on, announce, input ready);
  modport sink   (input valid, op, sense_sample, power_on, announce, output ready);
endinterface

interface otr_out_if;
  logic        valid;
  logic        ready;
  logic        track_enable;
  logic        tripped_flag;
  logic [15:0] current_ma;
  logic [1:0]  power_event;

  modport source (output valid, track_enable, tripped_flag, current_ma, power_event,
                  input ready);
  modport sink   (input valid, track_enable, tripped_flag, current_ma, power_event,
                  output ready);
endinterface

// ----- hw/rtl/otr_ctrl.sv -----
// ----------------------------------------------------------------------------
// otr_ctrl: sequencing state machine
// Takes one beat at a time, steps the datapath through products, average and
// scale for a checking tick, and holds commit until the result register is free.
// ----------------------------------------------------------------------------
module otr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_op,
  output logic                item_ready,
  input  otr_pkg::otr_status_t status,
  output otr_pkg::otr_cmd_t    cmd
);
  import otr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_AVG    = 3'd2;
  localparam logic [2:0] S_SCALE  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = (item_op == OP_TICK && status.check_hit) ? S_MUL : S_COMMIT;
        end
      end
      S_MUL: begin
        cmd.load_prod = 1'b1;
        state_next    = S_AVG;
      end
      S_AVG: begin
        cmd.load_avg = 1'b1;
        state_next   = S_SCALE;
      end
      S_SCALE: begin
        cmd.load_scale = 1'b1;
        state_next     = S_COMMIT;
      end
      S_COMMIT: begin
        if (status.slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_commit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.slot_free)
    else $error("commit while result register occupied");

  a_avg_after_prod: assert property (@(posedge clk) disable iff (rst)
    cmd.load_prod |=> cmd.load_avg)
    else $error("average update did not follow products");

endmodule

// ----- hw/rtl/otr_dp.sv -----
// ----------------------------------------------------------------------------
// otr_dp: trip datapath
// Configuration registers, tick counters, exponential average, milliamp
// scaling, trip/retry decision and the result register.
// ----------------------------------------------------------------------------
module otr_dp #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [otr_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  logic [otr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            op,
  input  logic [SAMPLE_BITS-1:0]          sense_sample,
  input  logic                            power_on,
  input  logic                            announce,
  input  otr_pkg::otr_cmd_t               cmd,
  output otr_pkg::otr_status_t            status,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            track_enable,
  output logic                            tripped_flag,
  output logic [15:0]                     current_ma,
  output logic [1:0]                      power_event
);
  import otr_pkg::*;

  localparam int AVG_W  = SAMPLE_BITS + 8;
  localparam int NEW_W  = SAMPLE_BITS + 9;
  localparam int OLD_W  = AVG_W + 9;
  localparam int PROD_W = SAMPLE_BITS + 16;
  localparam int MA_W   = SAMPLE_BITS + 8;

  logic [15:0] trip_current_ma;
  logic        programming_mode;
  logic [8:0]  smoothing_weight;
  logic [15:0] ma_per_count;
  logic [7:0]  sample_interval_ticks;
  logic [15:0] retry_ticks;

  logic             enable_level;
  logic             trip_latched;
  logic [AVG_W-1:0] smoothed_reading;
  logic [8:0]       ticks_since_check;
  logic [16:0]      ticks_since_trip;
  logic [15:0]      last_current;

  logic                   op_q;
  logic                   check_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   power_on_q;
  logic                   announce_q;
  logic [NEW_W-1:0]       prod_new;
  logic [OLD_W-1:0]       prod_old;
  logic [PROD_W-1:0]      ma_prod;

  logic [8:0]       tsc_inc;
  logic [16:0]      tst_inc;
  logic [8:0]       w_sat;
  logic [AVG_W:0]   avg_sum;
  logic [MA_W-1:0]  ma_full;
  logic [15:0]      ma_sat;
  logic [15:0]      limit;
  logic             trip_hit;
  logic             retry_hit;
  logic [1:0]       event_code;

  assign tsc_inc = (ticks_since_check < CHECK_MAX) ? ticks_since_check + 9'd1
                                                    : ticks_since_check;
  assign tst_inc = (ticks_since_trip < TRIP_MAX) ? ticks_since_trip + 17'd1
                                                  : ticks_since_trip;
  assign status.check_hit = tsc_inc > {1'b0, sample_interval_ticks};
  assign status.slot_free = !result_valid || result_ready;

  assign w_sat   = (cfg_wdata[8:0] > WEIGHT_ONE) ? WEIGHT_ONE : cfg_wdata[8:0];
  assign avg_sum = (AVG_W+1)'(prod_new) + (AVG_W+1)'(prod_old[OLD_W-1:8]);
  assign ma_full = ma_prod[PROD_W-1:8];
  assign ma_sat  = (ma_full > MA_W'(CURRENT_MAX)) ? CURRENT_MAX : ma_full[15:0];
  assign limit   = programming_mode ? PROG_LIMIT_MA : trip_current_ma;

  assign trip_hit  = check_q && (ma_sat > limit) && enable_level;
  assign retry_hit = check_q && !trip_hit && (ma_sat < limit) && trip_latched &&
                     (ticks_since_trip > {1'b0, retry_ticks});

  always_comb begin
    event_code = EV_NONE;
    if (op_q == OP_POWER) begin
      if (announce_q) begin
        event_code = power_on_q ? EV_ON : EV_OFF;
      end
    end else if (trip_hit) begin
      event_code = EV_OFF;
    end else if (retry_hit) begin
      event_code = EV_ON;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      trip_current_ma       <= RST_TRIP_CURRENT;
      programming_mode      <= 1'b0;
      smoothing_weight      <= RST_WEIGHT;
      ma_per_count          <= RST_MA_PER_COUNT;
      sample_interval_ticks <= RST_INTERVAL;
      retry_ticks           <= RST_RETRY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIP_CURRENT: trip_current_ma       <= cfg_wdata;
        REG_PROG_MODE:    programming_mode      <= cfg_wdata[0];
        REG_WEIGHT:       smoothing_weight      <= w_sat;
        REG_MA_PER_COUNT: ma_per_count          <= cfg_wdata;
        REG_INTERVAL:     sample_interval_ticks <= cfg_wdata[7:0];
        REG_RETRY:        retry_ticks           <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // track state
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_level      <= 1'b0;
      trip_latched      <= 1'b0;
      smoothed_reading  <= '0;
      ticks_since_check <= '0;
      ticks_since_trip  <= '0;
      last_current      <= '0;
      check_q           <= 1'b0;
    end else begin
      if (cmd.accept) begin
        check_q <= (op == OP_TICK) && status.check_hit;
        if (op == OP_TICK) begin
          ticks_since_check <= status.check_hit ? 9'd0 : tsc_inc;
          ticks_since_trip  <= tst_inc;
        end
      end
      if (cmd.load_avg) begin
        smoothed_reading <= avg_sum[AVG_W-1:0];
      end
      if (cmd.commit) begin
        if (op_q == OP_POWER) begin
          enable_level <= power_on_q;
        end else if (check_q) begin
          last_current <= ma_sat;
          if (trip_hit) begin
            enable_level     <= 1'b0;
            trip_latched     <= 1'b1;
            ticks_since_trip <= '0;
          end else if (retry_hit) begin
            enable_level <= 1'b1;
            trip_latched <= 1'b0;
          end
        end
      end
    end
  end

  // captured beat and products
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q       <= op;
      sample_q   <= sense_sample;
      power_on_q <= power_on;
      announce_q <= announce;
    end
    if (cmd.load_prod) begin
      prod_new <= NEW_W'(sample_q) * NEW_W'(smoothing_weight);
      prod_old <= OLD_W'(smoothed_reading) * OLD_W'(WEIGHT_ONE - smoothing_weight);
    end
    if (cmd.load_scale) begin
      ma_prod <= PROD_W'(smoothed_reading[AVG_W-1:8]) * PROD_W'(ma_per_count);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      track_enable <= (op_q == OP_POWER) ? power_on_q
                    : (trip_hit ? 1'b0 : (retry_hit ? 1'b1 : enable_level));
      tripped_flag <= (op_q == OP_POWER) ? trip_latched
                    : (trip_hit ? 1'b1 : (retry_hit ? 1'b0 : trip_latched));
      current_ma   <= (op_q == OP_TICK && check_q) ? ma_sat : last_current;
      power_event  <= event_code;
    end
  end

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    smoothing_weight <= WEIGHT_ONE)
    else $error("smoothing weight above one");

  a_trip_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && trip_hit |=> !enable_level && trip_latched && ticks_since_trip == '0)
    else $error("trip did not shut the track off");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (power_event == EV_NONE || power_event == EV_OFF ||
                      power_event == EV_ON))
    else $error("bad power event code");

  a_current_matches: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> current_ma == last_current)
    else $error("reported current differs from stored current");

endmodule

// ----- hw/rtl/track_overcurrent_trip_retry.sv -----
// ----------------------------------------------------------------------------
// track_overcurrent_trip_retry: overcurrent trip with automatic retry
// A command or a tick without a check goes from accept straight to the commit
//   state; a tick that runs a check first passes the products, average and
//   scale states. One beat at a time: the next beat is taken once the result
//   is in the output register, and the commit waits for a free result slot.
// Synchronous active-high reset restores the configuration defaults and turns
//   the track off.
// ----------------------------------------------------------------------------
module track_overcurrent_trip_retry #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  otr_in_if.sink                         item,
  otr_out_if.source                      result,
  input  logic                           cfg_we,
  input  logic [otr_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [otr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import otr_pkg::*;

  otr_cmd_t    cmd;
  otr_status_t status;
  logic        ready;
  logic [SAMPLE_BITS-1:0] sample;

  assign item.ready = ready;
  assign sample     = item.sense_sample;

  otr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_op    (item.op),
    .item_ready (ready),
    .status     (status),
    .cmd        (cmd)
  );

  otr_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .op           (item.op),
    .sense_sample (sample),
    .power_on     (item.power_on),
    .announce     (item.announce),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .track_enable (result.track_enable),
    .tripped_flag (result.tripped_flag),
    .current_ma   (result.current_ma),
    .power_event  (result.power_event)
  );

endmodule
